[hdl/cosine_similarity_unit_defines.svh]
// Assertion macros shared by the cosine similarity unit RTL.
`ifndef COSINE_SIMILARITY_UNIT_DEFINES_SVH
`define COSINE_SIMILARITY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold on every clock edge out of reset.
`define CSU_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("cosine_similarity_unit: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define CSU_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cosine_similarity_unit: implication violated");

`else

`define CSU_ASSERT_ALWAYS(label, cond)
`define CSU_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

[hdl/cs_pkg.sv]
// Shared types and fixed constants for the cosine similarity unit.
`default_nettype none

package cs_pkg;

	localparam int ELEM_PORT_W = 16;  // width of the element ports
	localparam int SIM_W       = 16;  // result width, Q1.15
	localparam int RES_BITS    = 16;  // quotient bits resolved by the root search
	localparam int SCALE_SHIFT = 30;  // 2^30 = (2^15)^2 scaling of dot^2
	localparam int DIGIT_W     = 8;   // multiplier digit per cycle

	typedef struct packed {
		logic [SIM_W-1:0] similarity;
		logic             zero_norm;
	} result_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_PREP = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_CMP  = 6'b010000,
		ST_DONE = 6'b100000
	} back_state_t;

endpackage

`default_nettype wire

[hdl/cs_fifo.sv]
// Small register queue with push/full and pop/empty sides.
`default_nettype none

module cs_fifo #(
	parameter int W     = 1,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr;
	logic             rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push & ~full;
	assign rd    = pop & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (wr && !rd) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (rd && !wr) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[hdl/cs_front.sv]
// Front end: takes element transactions and accumulates dot product and norms.
`default_nettype none

module cs_front #(
	parameter int MAX_TOPICS   = 32,
	parameter int ELEMENT_BITS = 16,
	localparam int ACC_W       = 2 * ELEMENT_BITS + 6,
	localparam int JOB_W       = 3 * ACC_W + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_push,
	output logic                               in_full,
	input  wire logic [cs_pkg::ELEM_PORT_W-1:0] elem_a,
	input  wire logic [cs_pkg::ELEM_PORT_W-1:0] elem_b,
	input  wire logic                          self_pair,
	input  wire logic                          last,
	output logic                               job_push,
	input  wire logic                          job_full,
	output logic [JOB_W-1:0]                   job_data
);

	localparam int XW    = (ELEMENT_BITS > cs_pkg::ELEM_PORT_W) ?
		ELEMENT_BITS : cs_pkg::ELEM_PORT_W;
	localparam int CNT_W = $clog2(MAX_TOPICS + 1);

	logic [XW-1:0]             a_x;
	logic [XW-1:0]             b_x;
	logic [ELEMENT_BITS-1:0]   a;
	logic [ELEMENT_BITS-1:0]   b;
	logic [2*ELEMENT_BITS-1:0] ab;
	logic [2*ELEMENT_BITS-1:0] aa;
	logic [2*ELEMENT_BITS-1:0] bb;
	logic [ACC_W-1:0]          dot_q;
	logic [ACC_W-1:0]          na_q;
	logic [ACC_W-1:0]          nb_q;
	logic [ACC_W-1:0]          dot_nx;
	logic [ACC_W-1:0]          na_nx;
	logic [ACC_W-1:0]          nb_nx;
	logic [CNT_W-1:0]          count_q;
	logic                      accept;
	logic                      take;

	assign a_x = XW'(elem_a);
	assign b_x = XW'(elem_b);
	assign a   = a_x[ELEMENT_BITS-1:0];
	assign b   = b_x[ELEMENT_BITS-1:0];
	assign ab  = a * b;
	assign aa  = a * a;
	assign bb  = b * b;

	// stall only when the job queue cannot take a finished pair
	assign in_full = job_full;
	assign accept  = in_push & ~in_full;
	// elements beyond the topic limit are dropped
	assign take    = (count_q < CNT_W'(MAX_TOPICS));

	assign dot_nx = take ? ACC_W'(dot_q + ACC_W'(ab)) : dot_q;
	assign na_nx  = take ? ACC_W'(na_q + ACC_W'(aa)) : na_q;
	assign nb_nx  = take ? ACC_W'(nb_q + ACC_W'(bb)) : nb_q;

	assign job_push = accept & last;
	assign job_data = {self_pair, dot_nx, na_nx, nb_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			na_q    <= '0;
			nb_q    <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				dot_q   <= '0;
				na_q    <= '0;
				nb_q    <= '0;
				count_q <= '0;
			end else begin
				dot_q <= dot_nx;
				na_q  <= na_nx;
				nb_q  <= nb_nx;
				if (take) begin
					count_q <= CNT_W'(count_q + 1'b1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[hdl/cs_back.sv]
// Back end: digit-serial products and bit-serial root search for one pair.
`default_nettype none

module cs_back #(
	parameter int ELEMENT_BITS = 16,
	localparam int ACC_W       = 2 * ELEMENT_BITS + 6,
	localparam int JOB_W       = 3 * ACC_W + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_empty,
	output logic                  job_pop,
	input  wire logic [JOB_W-1:0] job_data,
	output logic                  res_push,
	input  wire logic             res_full,
	output cs_pkg::result_t       res_data
);

	localparam int NDIG   = (ACC_W + cs_pkg::DIGIT_W - 1) / cs_pkg::DIGIT_W;
	localparam int DIG_PW = NDIG * cs_pkg::DIGIT_W;
	localparam int PROD_W = 2 * ACC_W;
	localparam int SUM_W  = PROD_W + 2 * cs_pkg::RES_BITS;
	localparam int DCNT_W = $clog2(NDIG);
	localparam int BIT_W  = $clog2(cs_pkg::RES_BITS);
	localparam int PS_SH  = 2 * (cs_pkg::RES_BITS - 1);

	cs_pkg::back_state_t state_q;
	cs_pkg::back_state_t state_d;

	logic [ACC_W-1:0]                 dot_q;
	logic [ACC_W-1:0]                 na_q;
	logic [DIG_PW-1:0]                nbdig_q;
	logic [DIG_PW-1:0]                dotdig_q;
	logic [PROD_W-1:0]                prod_q;
	logic [PROD_W-1:0]                dsq_q;
	logic [DCNT_W-1:0]                dig_q;
	logic [SUM_W-1:0]                 s_q;
	logic [SUM_W-1:0]                 ts_q;
	logic [SUM_W-1:0]                 ps_q;
	logic [SUM_W-1:0]                 cand_q;
	logic [SUM_W-1:0]                 dlim;
	logic [cs_pkg::RES_BITS-1:0]      q_q;
	logic [BIT_W-1:0]                 bit_q;
	cs_pkg::result_t                  res_q;
	logic [ACC_W+cs_pkg::DIGIT_W-1:0] pp_p;
	logic [ACC_W+cs_pkg::DIGIT_W-1:0] pp_d;
	logic                             job_self;
	logic [ACC_W-1:0]                 job_dot;
	logic [ACC_W-1:0]                 job_na;
	logic [ACC_W-1:0]                 job_nb;
	logic                             fit;
	logic                             mul_end;

	assign job_self = job_data[JOB_W-1];
	assign job_dot  = job_data[3*ACC_W-1:2*ACC_W];
	assign job_na   = job_data[2*ACC_W-1:ACC_W];
	assign job_nb   = job_data[ACC_W-1:0];

	assign job_pop  = (state_q == cs_pkg::ST_IDLE) & ~job_empty;
	assign res_push = (state_q == cs_pkg::ST_DONE) & ~res_full;
	assign res_data = res_q;

	// top digit first, accumulator shifts up one digit per cycle
	assign pp_p    = na_q * nbdig_q[DIG_PW-1 -: cs_pkg::DIGIT_W];
	assign pp_d    = dot_q * dotdig_q[DIG_PW-1 -: cs_pkg::DIGIT_W];
	assign mul_end = (dig_q == DCNT_W'(NDIG - 1));

	assign dlim = SUM_W'({dsq_q, {cs_pkg::SCALE_SHIFT{1'b0}}});
	assign fit  = (cand_q <= dlim);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cs_pkg::ST_IDLE: begin
				if (!job_empty) begin
					if (job_self || job_na == '0 || job_nb == '0) begin
						state_d = cs_pkg::ST_DONE;
					end else begin
						state_d = cs_pkg::ST_MUL;
					end
				end
			end
			cs_pkg::ST_MUL: begin
				if (mul_end) begin
					state_d = cs_pkg::ST_PREP;
				end
			end
			cs_pkg::ST_PREP: state_d = cs_pkg::ST_SUM;
			cs_pkg::ST_SUM:  state_d = cs_pkg::ST_CMP;
			cs_pkg::ST_CMP: begin
				if (bit_q == '0) begin
					state_d = cs_pkg::ST_DONE;
				end else begin
					state_d = cs_pkg::ST_SUM;
				end
			end
			cs_pkg::ST_DONE: begin
				if (!res_full) begin
					state_d = cs_pkg::ST_IDLE;
				end
			end
			default: state_d = cs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// S = q^2*P, Ts = q*P << (k+1), Ps = P << 2k; try bit k when S+Ts+Ps <= D
	always_ff @(posedge clk) begin
		case (state_q)
			cs_pkg::ST_IDLE: begin
				dot_q    <= job_dot;
				na_q     <= job_na;
				nbdig_q  <= DIG_PW'(job_nb);
				dotdig_q <= DIG_PW'(job_dot);
				prod_q   <= '0;
				dsq_q    <= '0;
				dig_q    <= '0;
				res_q.similarity <= '0;
				res_q.zero_norm  <= ~job_self & (job_na == '0 || job_nb == '0);
			end
			cs_pkg::ST_MUL: begin
				prod_q   <= PROD_W'((prod_q << cs_pkg::DIGIT_W) + PROD_W'(pp_p));
				dsq_q    <= PROD_W'((dsq_q << cs_pkg::DIGIT_W) + PROD_W'(pp_d));
				nbdig_q  <= nbdig_q << cs_pkg::DIGIT_W;
				dotdig_q <= dotdig_q << cs_pkg::DIGIT_W;
				dig_q    <= DCNT_W'(dig_q + 1'b1);
			end
			cs_pkg::ST_PREP: begin
				s_q   <= '0;
				ts_q  <= '0;
				ps_q  <= SUM_W'({prod_q, {PS_SH{1'b0}}});
				q_q   <= '0;
				bit_q <= BIT_W'(cs_pkg::RES_BITS - 1);
			end
			cs_pkg::ST_SUM: begin
				cand_q <= SUM_W'(s_q + ts_q + ps_q);
			end
			cs_pkg::ST_CMP: begin
				q_q[bit_q] <= fit;
				if (fit) begin
					s_q <= cand_q;
				end
				ts_q  <= SUM_W'((ts_q >> 1) + (fit ? ps_q : '0));
				ps_q  <= ps_q >> 2;
				bit_q <= BIT_W'(bit_q - 1'b1);
				if (bit_q == '0) begin
					res_q.similarity <= cs_pkg::SIM_W'({q_q[cs_pkg::RES_BITS-1:1], fit});
					res_q.zero_norm  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[hdl/cosine_similarity_unit.sv]
// Top level of the cosine similarity unit.
`default_nettype none
`include "cosine_similarity_unit_defines.svh"

// Cosine similarity of a pair of topic vectors, streamed one element pair per
// transaction (unsigned Q0.16 elements, low ELEMENT_BITS bits used). The front
// end takes one element transaction per cycle while full is low and keeps
// exact dot product and squared norms; elements after the first MAX_TOPICS
// of a pair are dropped. The transaction marked last closes the pair and
// hands its sums to a two-entry job queue, so the next pair can start
// streaming at once. The back end works out Q1.15 (32768 = 1.0) values of
// floor(32768 * dot / sqrt(na * nb)): it takes the job, runs an 8-bit
// digit-serial multiplier over ceil((2*ELEMENT_BITS+6)/8) digits for na*nb
// and dot^2, sets up, then runs a bit-serial square-root style search with
// a sum and a compare step per result bit (16 bits), and posts the result.
// A self pair gives 0 with zero_norm clear; a zero norm in any other pair
// gives 0 with zero_norm set, both skipping the multiply and search. Results
// wait in a two-entry output queue. Element transactions go at full rate as
// long as pairs average at least the back-end time and results are popped;
// otherwise full rises once two finished pairs wait behind the current one.

module cosine_similarity_unit #(
	parameter int MAX_TOPICS   = 32,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [cs_pkg::ELEM_PORT_W-1:0] elem_a,
	input  wire logic [cs_pkg::ELEM_PORT_W-1:0] elem_b,
	input  wire logic                           self_pair,
	input  wire logic                           last,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [cs_pkg::SIM_W-1:0]            similarity,
	output logic                                zero_norm
);

	localparam int ACC_W = 2 * ELEMENT_BITS + 6;
	localparam int JOB_W = 3 * ACC_W + 1;
	localparam int RES_W = $bits(cs_pkg::result_t);

	// front end to job queue
	logic             job_push;
	logic             job_full;
	logic [JOB_W-1:0] job_wdata;
	// job queue to back end
	logic             job_pop;
	logic             job_empty;
	logic [JOB_W-1:0] job_rdata;
	// back end to result queue
	logic             res_push;
	logic             res_full;
	cs_pkg::result_t  res_wdata;
	logic [RES_W-1:0] res_rdata;
	cs_pkg::result_t  res_head;

	cs_front #(
		.MAX_TOPICS   (MAX_TOPICS),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (push),
		.in_full   (full),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.self_pair (self_pair),
		.last      (last),
		.job_push  (job_push),
		.job_full  (job_full),
		.job_data  (job_wdata)
	);

	cs_fifo #(
		.W     (JOB_W),
		.DEPTH (2)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.wdata  (job_wdata),
		.pop    (job_pop),
		.empty  (job_empty),
		.rdata  (job_rdata)
	);

	cs_back #(
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job_data  (job_rdata),
		.res_push  (res_push),
		.res_full  (res_full),
		.res_data  (res_wdata)
	);

	cs_fifo #(
		.W     (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_wdata),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	assign res_head   = cs_pkg::result_t'(res_rdata);
	assign similarity = res_head.similarity;
	assign zero_norm  = res_head.zero_norm;

	// a finished pair is never offered to a full job queue
	`CSU_ASSERT_IMPLIES(a_job_no_overflow, job_push, !job_full)
	// the back end only takes a job that is there
	`CSU_ASSERT_IMPLIES(a_job_no_underrun, job_pop, !job_empty)
	// a zero-norm result always carries similarity zero
	`CSU_ASSERT_IMPLIES(a_zero_norm_sim, !empty && zero_norm, similarity == '0)
	// the root search never climbs above 1.0
	`CSU_ASSERT_IMPLIES(a_sim_range, !empty, similarity <= 16'd32768)

endmodule

`default_nettype wire
